FILE: sv/pgc_pkg.sv
// ----------------------------------------------------------------------------
// pgc_pkg
// shared types, constants and helpers of the packed genotype counter
// ----------------------------------------------------------------------------
package pgc_pkg;

  localparam int Lanes    = 4;
  localparam int CodeW    = 2;
  localparam int NumCodes = 4;
  localparam int CtrW     = 24;
  localparam int RowW     = 13;
  localparam int ClassW   = 2;
  localparam int ByteIdxW = 10;
  localparam int AddrW    = ClassW + ByteIdxW;
  localparam int CntW     = 3;
  localparam int SelW     = 2;

  localparam logic [CodeW-1:0]  CodeMissing = 2'd3;
  localparam logic [ClassW-1:0] ClassX      = 2'd1;
  localparam logic [ClassW-1:0] ClassY      = 2'd2;
  localparam logic [RowW-1:0]   RowMax      = {RowW{1'b1}};
  localparam logic [CtrW-1:0]   CtrMax      = {CtrW{1'b1}};

  typedef enum logic {
    CmdGeno = 1'b0,
    CmdRead = 1'b1
  } cmd_e;

  typedef enum logic {
    KindRow     = 1'b0,
    KindReadout = 1'b1
  } kind_e;

  typedef logic [CtrW-1:0] ctr_t;
  typedef ctr_t [NumCodes-1:0] ctr_word_t;

  typedef struct packed {
    logic              rd_en;
    logic              upd;
    logic [CodeW-1:0]  code;
    logic [AddrW-1:0]  addr;
  } lane_req_t;

  typedef struct packed {
    logic [NumCodes-1:0] code_oh;
    logic [NumCodes-1:0] fem_oh;
    logic                male;
  } lane_tally_t;

  typedef struct packed {
    logic [RowW-1:0] zero;
    logic [RowW-1:0] one;
    logic [RowW-1:0] two;
    logic [RowW-1:0] missing;
    logic [RowW-1:0] fzero;
    logic [RowW-1:0] fone;
    logic [RowW-1:0] ftwo;
    logic [RowW-1:0] fmissing;
  } row_result_t;

  function automatic logic [RowW-1:0] sat_row(logic [RowW-1:0] a, logic [CntW-1:0] b);
    logic [RowW:0] s;
    s = {1'b0, a} + (RowW+1)'(b);
    return s[RowW] ? RowMax : s[RowW-1:0];
  endfunction

endpackage

FILE: sv/pgc_lane.sv
// ----------------------------------------------------------------------------
// pgc_lane
// one genotype slot lane: per-individual counter memory with read-modify-write
// ----------------------------------------------------------------------------
module pgc_lane (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pgc_pkg::lane_req_t       req_i,
  input  logic                     adv_i,
  input  logic                     clr_i,
  input  logic [pgc_pkg::AddrW-1:0] clr_addr_i,
  output pgc_pkg::ctr_word_t       word_o
);
  import pgc_pkg::*;

  localparam int Depth = 1 << AddrW;

  ctr_word_t        mem [Depth];
  ctr_word_t        rd_q;
  logic             upd_q;
  logic [AddrW-1:0] addr_q;
  logic [CodeW-1:0] code_q;
  logic             fwd_valid_q;
  logic [AddrW-1:0] fwd_addr_q;
  ctr_word_t        fwd_word_q;

  ctr_word_t        cur;
  ctr_word_t        upd_word;
  logic             we;
  logic [AddrW-1:0] wa;
  ctr_word_t        wd;

  always_comb begin
    cur = (fwd_valid_q && fwd_addr_q == addr_q) ? fwd_word_q : rd_q;
    upd_word = cur;
    if (cur[code_q] != CtrMax) begin
      upd_word[code_q] = cur[code_q] + ctr_t'(1);
    end
    we = clr_i || (adv_i && upd_q);
    wa = clr_i ? clr_addr_i : addr_q;
    wd = clr_i ? '0 : upd_word;
  end

  assign word_o = cur;

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.addr];
    end
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upd_q       <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      if (req_i.rd_en) begin
        upd_q <= req_i.upd;
      end else if (adv_i) begin
        upd_q <= 1'b0;
      end
      if (clr_i) begin
        fwd_valid_q <= 1'b0;
      end else if (we) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      addr_q <= req_i.addr;
      code_q <= req_i.code;
    end
    if (we) begin
      fwd_addr_q <= wa;
      fwd_word_q <= wd;
    end
  end

endmodule

FILE: sv/pgc_merge.sv
// ----------------------------------------------------------------------------
// pgc_merge
// merges lane tallies into running row totals and forms the row result
// ----------------------------------------------------------------------------
module pgc_merge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          upd_i,
  input  logic                          last_i,
  input  logic                          xy_i,
  input  logic [1:0]                    pad_i,
  input  pgc_pkg::lane_tally_t [pgc_pkg::Lanes-1:0] tally_i,
  output pgc_pkg::row_result_t          res_o
);
  import pgc_pkg::*;

  logic [RowW-1:0] row_q  [NumCodes];
  logic [RowW-1:0] frow_q [NumCodes];
  logic [RowW-1:0] male_q;

  logic [CntW-1:0] cnt  [NumCodes];
  logic [CntW-1:0] fcnt [NumCodes];
  logic [CntW-1:0] mcnt;
  logic [RowW-1:0] row_d  [NumCodes];
  logic [RowW-1:0] frow_d [NumCodes];
  logic [RowW-1:0] male_d;
  logic [RowW:0]   fsub;

  always_comb begin
    mcnt = '0;
    for (int j = 0; j < NumCodes; j++) begin
      cnt[j]  = '0;
      fcnt[j] = '0;
    end
    for (int l = 0; l < Lanes; l++) begin
      mcnt = mcnt + CntW'(tally_i[l].male);
      for (int j = 0; j < NumCodes; j++) begin
        cnt[j]  = cnt[j] + CntW'(tally_i[l].code_oh[j]);
        fcnt[j] = fcnt[j] + CntW'(tally_i[l].fem_oh[j]);
      end
    end
    for (int j = 0; j < NumCodes; j++) begin
      row_d[j]  = sat_row(row_q[j], cnt[j]);
      frow_d[j] = xy_i ? sat_row(frow_q[j], fcnt[j]) : frow_q[j];
    end
    male_d = sat_row(male_q, mcnt);
    fsub   = (RowW+1)'(pad_i) + (RowW+1)'(male_d);

    res_o.zero    = row_d[0];
    res_o.one     = row_d[1];
    res_o.two     = row_d[2];
    res_o.missing = (row_d[3] > RowW'(pad_i)) ? row_d[3] - RowW'(pad_i) : '0;
    if (xy_i) begin
      res_o.fzero    = frow_d[0];
      res_o.fone     = frow_d[1];
      res_o.ftwo     = frow_d[2];
      res_o.fmissing = ({1'b0, frow_d[3]} > fsub) ?
                       RowW'({1'b0, frow_d[3]} - fsub) : '0;
    end else begin
      res_o.fzero    = '0;
      res_o.fone     = '0;
      res_o.ftwo     = '0;
      res_o.fmissing = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NumCodes; j++) begin
        row_q[j]  <= '0;
        frow_q[j] <= '0;
      end
      male_q <= '0;
    end else if (upd_i) begin
      for (int j = 0; j < NumCodes; j++) begin
        row_q[j]  <= last_i ? '0 : row_d[j];
        frow_q[j] <= last_i ? '0 : frow_d[j];
      end
      male_q <= last_i ? '0 : male_d;
    end
  end

endmodule

FILE: sv/packed_genotype_counter_core.sv
// ----------------------------------------------------------------------------
// packed_genotype_counter_core
// four-lane packed 2-bit genotype counter with per-individual counters
// ----------------------------------------------------------------------------
// One transaction is accepted per clock while in_stall_o is low. Four lanes
// handle the four genotype slots of a byte in parallel, each with its own
// counter memory (class and byte index address, one 24-bit counter per code)
// updated by read-modify-write with forwarding; a merge stage sums the lane
// tallies into the row totals. A result passes the stage-1 register and then
// the output register after its byte or read command is accepted; the memory
// read is registered alongside stage 1. After reset a clearing pass over all
// 4096 addresses zeroes the counter memories, and in_stall_o stays high during
// it; configuration writes are taken at all times.
module packed_genotype_counter_core
  import pgc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_pad_slots_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  geno_byte_i,
  input  logic [9:0]  byte_index_i,
  input  logic [1:0]  chrom_class_i,
  input  logic [3:0]  male_mask_i,
  input  logic        last_in_row_i,
  input  logic [11:0] individual_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [23:0] count_zero_o,
  output logic [23:0] count_one_o,
  output logic [23:0] count_two_o,
  output logic [23:0] count_missing_o,
  output logic [12:0] female_zero_o,
  output logic [12:0] female_one_o,
  output logic [12:0] female_two_o,
  output logic [12:0] female_missing_o
);

  logic [1:0]       pad_q;
  logic [AddrW:0]   clr_q;
  logic             clearing;
  logic             accept;
  logic             is_read;
  logic             xy;
  logic             out_blocked;
  logic             adv;
  logic [Lanes-1:0] padmask;

  lane_req_t   [Lanes-1:0] req;
  lane_tally_t [Lanes-1:0] tally;
  ctr_word_t               lane_word [Lanes];
  row_result_t             row_res;

  logic            s1_valid_q;
  logic            s1_res_q;
  logic            s1_kind_q;
  logic [SelW-1:0] s1_sel_q;
  row_result_t     s1_row_q;

  logic        out_valid_q;
  logic        kind_q;
  ctr_word_t   cnt_q;
  logic [RowW-1:0] fem_q [NumCodes];
  ctr_word_t   sel_word;

  assign cfg_ready_o = 1'b1;
  assign clearing    = !clr_q[AddrW];
  assign out_blocked = out_valid_q && out_stall_i;
  assign adv         = !out_blocked;
  assign in_stall_o  = clearing || (s1_valid_q && out_blocked);
  assign accept      = in_valid_i && !in_stall_o;
  assign is_read     = (cmd_i == CmdRead);
  assign xy          = (chrom_class_i == ClassX) || (chrom_class_i == ClassY);

  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      padmask[k] = last_in_row_i && (3'(k) >= 3'(Lanes) - 3'(pad_q));
    end
  end

  for (genvar k = 0; k < Lanes; k++) begin : g_lane
    logic [CodeW-1:0] code;
    logic             male;
    assign code = geno_byte_i[CodeW*k +: CodeW];
    assign male = male_mask_i[k] && !padmask[k];

    assign req[k].rd_en = accept;
    assign req[k].upd   = !is_read && !padmask[k];
    assign req[k].code  = code;
    assign req[k].addr  = is_read ? {chrom_class_i, individual_i[11:2]}
                                  : {chrom_class_i, byte_index_i};

    assign tally[k].code_oh = NumCodes'(1) << code;
    assign tally[k].fem_oh  = NumCodes'(1) << (male ? CodeMissing : code);
    assign tally[k].male    = male;

    pgc_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .req_i      (req[k]),
      .adv_i      (adv),
      .clr_i      (clearing),
      .clr_addr_i (clr_q[AddrW-1:0]),
      .word_o     (lane_word[k])
    );
  end

  pgc_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (accept && !is_read),
    .last_i  (last_in_row_i),
    .xy_i    (xy),
    .pad_i   (pad_q),
    .tally_i (tally),
    .res_o   (row_res)
  );

  assign sel_word = lane_word[s1_sel_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_q       <= '0;
      clr_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        pad_q <= cfg_pad_slots_i;
      end
      if (clearing) begin
        clr_q <= clr_q + (AddrW+1)'(1);
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q && s1_res_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q  <= is_read || last_in_row_i;
      s1_kind_q <= is_read ? KindReadout : KindRow;
      s1_sel_q  <= individual_i[SelW-1:0];
      s1_row_q  <= row_res;
    end
    if (adv && s1_valid_q && s1_res_q) begin
      kind_q <= s1_kind_q;
      if (s1_kind_q == KindReadout) begin
        cnt_q <= sel_word;
        for (int j = 0; j < NumCodes; j++) begin
          fem_q[j] <= '0;
        end
      end else begin
        cnt_q[0] <= CtrW'(s1_row_q.zero);
        cnt_q[1] <= CtrW'(s1_row_q.one);
        cnt_q[2] <= CtrW'(s1_row_q.two);
        cnt_q[3] <= CtrW'(s1_row_q.missing);
        fem_q[0] <= s1_row_q.fzero;
        fem_q[1] <= s1_row_q.fone;
        fem_q[2] <= s1_row_q.ftwo;
        fem_q[3] <= s1_row_q.fmissing;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign count_zero_o     = cnt_q[0];
  assign count_one_o      = cnt_q[1];
  assign count_two_o      = cnt_q[2];
  assign count_missing_o  = cnt_q[3];
  assign female_zero_o    = fem_q[0];
  assign female_one_o     = fem_q[1];
  assign female_two_o     = fem_q[2];
  assign female_missing_o = fem_q[3];

endmodule

FILE: sv/pgc_checker.sv
// ----------------------------------------------------------------------------
// pgc_checker
// port-level checks of the packed genotype counter, bound to the top level
// ----------------------------------------------------------------------------
module pgc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_ready_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        kind_o,
  input logic [23:0] count_zero_o,
  input logic [23:0] count_missing_o,
  input logic [12:0] female_zero_o,
  input logic [12:0] female_one_o,
  input logic [12:0] female_two_o,
  input logic [12:0] female_missing_o
);
  import pgc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o)
      && $stable(count_zero_o) && $stable(female_missing_o))
    else $error("stalled output transaction changed");

  a_readout_female: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindReadout |->
      female_zero_o == '0 && female_one_o == '0 && female_two_o == '0
      && female_missing_o == '0)
    else $error("readout carries female counts");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindRow |->
      count_zero_o[23:13] == '0 && count_missing_o[23:13] == '0)
    else $error("row total beyond row counter range");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind packed_genotype_counter_core pgc_checker u_pgc_checker (.*);

FILE: test/packed_genotype_counter_core_tb.sv
// ----------------------------------------------------------------------------
// packed_genotype_counter_core_tb
// self-checking bench: random and directed genotype rows and counter reads,
// results predicted in-bench and compared in order, random idle and stall
// ----------------------------------------------------------------------------
module packed_genotype_counter_core_tb;
  import pgc_pkg::*;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  geno;
    logic [9:0]  bidx;
    logic [1:0]  cls;
    logic [3:0]  mmask;
    logic        last;
    logic [11:0] indiv;
  } geno_txn_t;

  typedef struct packed {
    logic        kind;
    logic [23:0] c0, c1, c2, c3;
    logic [12:0] f0, f1, f2, f3;
  } tally_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_pad_slots_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic cmd_i = 1'b0;
  logic [7:0] geno_byte_i = '0;
  logic [9:0] byte_index_i = '0;
  logic [1:0] chrom_class_i = '0;
  logic [3:0] male_mask_i = '0;
  logic last_in_row_i = 1'b0;
  logic [11:0] individual_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic kind_o;
  logic [23:0] count_zero_o, count_one_o, count_two_o, count_missing_o;
  logic [12:0] female_zero_o, female_one_o, female_two_o, female_missing_o;

  packed_genotype_counter_core u_top (.*);

  always #5 clk_i = ~clk_i;

  geno_txn_t pending_q[$];
  tally_t    expected_q[$];
  int        errors = 0;
  logic      calm = 1'b0;
  logic      hold = 1'b0;
  logic [1:0] pad;
  logic [12:0] row_cnt[4], fem_cnt[4], males;
  logic [23:0] indiv_ctr[4][4096][4];

  function automatic logic [12:0] sat13(logic [12:0] a, int b);
    return (int'(a) + b > 8191) ? 13'd8191 : 13'(int'(a) + b);
  endfunction

  function automatic int floor_sub(int a, int b);
    return a > b ? a - b : 0;
  endfunction

  task automatic predict_counts(geno_txn_t t);
    logic [3:0] padm, mm;
    logic [7:0] fb;
    int code, ind, cnt[4], fcnt[4];
    tally_t r;
    logic xy;
    xy = (t.cls == ClassX) || (t.cls == ClassY);
    r = '0;
    if (t.cmd == CmdRead) begin
      r.kind = KindReadout;
      for (int j = 0; j < 4; j++) begin
        case (j)
          0: r.c0 = indiv_ctr[t.cls][t.indiv][0];
          1: r.c1 = indiv_ctr[t.cls][t.indiv][1];
          2: r.c2 = indiv_ctr[t.cls][t.indiv][2];
          default: r.c3 = indiv_ctr[t.cls][t.indiv][3];
        endcase
      end
      expected_q.push_back(r);
      return;
    end
    padm = t.last ? 4'((4'hf << (4 - pad)) & 4'hf) : 4'h0;
    mm = t.mmask & ~padm;
    fb = t.geno;
    cnt = '{0, 0, 0, 0};
    fcnt = '{0, 0, 0, 0};
    for (int k = 0; k < 4; k++) begin
      code = (t.geno >> (2 * k)) & 3;
      cnt[code]++;
      if (mm[k]) begin
        fb |= 8'(3 << (2 * k));
        males = sat13(males, 1);
      end
      if (!padm[k]) begin
        ind = t.bidx * 4 + k;
        if (ind < 4096 && indiv_ctr[t.cls][ind][code] != CtrMax)
          indiv_ctr[t.cls][ind][code]++;
      end
    end
    for (int k = 0; k < 4; k++) fcnt[(fb >> (2 * k)) & 3]++;
    for (int j = 0; j < 4; j++) begin
      row_cnt[j] = sat13(row_cnt[j], cnt[j]);
      if (xy) fem_cnt[j] = sat13(fem_cnt[j], fcnt[j]);
    end
    if (!t.last) return;
    r.kind = KindRow;
    r.c0 = 24'(row_cnt[0]);
    r.c1 = 24'(row_cnt[1]);
    r.c2 = 24'(row_cnt[2]);
    r.c3 = 24'(floor_sub(row_cnt[3], pad));
    if (xy) begin
      r.f0 = fem_cnt[0];
      r.f1 = fem_cnt[1];
      r.f2 = fem_cnt[2];
      r.f3 = 13'(floor_sub(fem_cnt[3], pad + males));
    end
    expected_q.push_back(r);
    for (int j = 0; j < 4; j++) begin
      row_cnt[j] = '0;
      fem_cnt[j] = '0;
    end
    males = '0;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      predict_counts(pending_q.pop_front());
    end
    if (in_valid_i && in_stall_o) begin
    end else if (pending_q.size() > 0 && !hold && (calm || $urandom_range(99) >= 7)) begin
      in_valid_i <= 1'b1;
      cmd_i <= pending_q[0].cmd;
      geno_byte_i <= pending_q[0].geno;
      byte_index_i <= pending_q[0].bidx;
      chrom_class_i <= pending_q[0].cls;
      male_mask_i <= pending_q[0].mmask;
      last_in_row_i <= pending_q[0].last;
      individual_i <= pending_q[0].indiv;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    tally_t got, exp_r;
    if (out_valid_o && !out_stall_i) begin
      got = {kind_o, count_zero_o, count_one_o, count_two_o, count_missing_o,
             female_zero_o, female_one_o, female_two_o, female_missing_o};
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result %h", $time, got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got.kind !== exp_r.kind)
          $display("%0t kind exp %h got %h", $time, exp_r.kind, got.kind);
        if (got.c0 !== exp_r.c0) $display("%0t zero exp %0d got %0d", $time, exp_r.c0, got.c0);
        if (got.c1 !== exp_r.c1) $display("%0t one exp %0d got %0d", $time, exp_r.c1, got.c1);
        if (got.c2 !== exp_r.c2) $display("%0t two exp %0d got %0d", $time, exp_r.c2, got.c2);
        if (got.c3 !== exp_r.c3)
          $display("%0t missing exp %0d got %0d", $time, exp_r.c3, got.c3);
        if (got.f0 !== exp_r.f0) $display("%0t fzero exp %0d got %0d", $time, exp_r.f0, got.f0);
        if (got.f1 !== exp_r.f1) $display("%0t fone exp %0d got %0d", $time, exp_r.f1, got.f1);
        if (got.f2 !== exp_r.f2) $display("%0t ftwo exp %0d got %0d", $time, exp_r.f2, got.f2);
        if (got.f3 !== exp_r.f3)
          $display("%0t fmissing exp %0d got %0d", $time, exp_r.f3, got.f3);
        if (got !== exp_r) errors++;
      end
    end
    out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 7);
  end

  task automatic add_byte(logic [7:0] g, logic [9:0] b, logic [1:0] c, logic [3:0] m,
                          logic l);
    pending_q.push_back('{CmdGeno, g, b, c, m, l, 12'($urandom)});
  endtask

  task automatic add_read(logic [1:0] c, logic [11:0] i);
    pending_q.push_back('{CmdRead, 8'($urandom), 10'($urandom), c, 4'($urandom),
                          1'($urandom), i});
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || expected_q.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_pad(logic [1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_pad_slots_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    pad = v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_row(logic [1:0] c);
    int n;
    logic [9:0] b0;
    n = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 6);
    b0 = ($urandom_range(7) == 0) ? 10'($urandom_range(1000, 1023)) : 10'($urandom_range(20));
    for (int i = 0; i < n; i++)
      add_byte(8'($urandom), 10'(b0 + i), c, 4'($urandom), i == n - 1);
  endtask

  initial begin
    int produced;
    pad = '0;
    for (int j = 0; j < 4; j++) begin
      row_cnt[j] = '0;
      fem_cnt[j] = '0;
    end
    males = '0;
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4096; i++)
        for (int j = 0; j < 4; j++) indiv_ctr[c][i][j] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_pad(2'd3);
    add_byte(8'h00, 10'd0, 2'd0, 4'h0, 1'b0);
    add_byte(8'hff, 10'd1, ClassX, 4'hf, 1'b0);
    add_byte(8'h1b, 10'd2, ClassY, 4'h5, 1'b1);
    add_byte(8'hff, 10'd1023, ClassX, 4'hf, 1'b1);
    add_byte(8'h00, 10'd1023, 2'd3, 4'ha, 1'b1);
    add_byte(8'he4, 10'd5, ClassX, 4'h0, 1'b1);
    add_read(ClassX, 12'd4);
    add_read(ClassY, 12'd9);
    add_read(2'd0, 12'd0);
    add_read(2'd3, 12'd4095);
    drain();
    set_pad(2'd0);
    add_byte(8'hff, 10'd3, 2'd0, 4'hf, 1'b1);
    add_byte(8'h55, 10'd3, ClassY, 4'h3, 1'b1);
    add_byte(8'haa, 10'd7, ClassX, 4'hc, 1'b0);
    add_byte(8'h27, 10'd8, 2'd0, 4'h1, 1'b1);
    add_read(ClassX, 12'd28);
    add_read(ClassY, 12'd12);
    hold = 1'b1;
    repeat (3) @(posedge clk_i);
    hold = 1'b0;
    drain();
    produced = 0;
    for (int ph = 0; ph < 4; ph++) begin
      set_pad(ph == 3 ? 2'd2 : 2'(ph == 0 ? 1 : ph == 1 ? 3 : 0));
      calm = (ph == 2);
      while (produced < (ph + 1) * 215) begin
        if ($urandom_range(3) == 0) begin
          add_read(2'($urandom), ($urandom_range(9) == 0) ? 12'($urandom)
                   : 12'($urandom_range(100)));
          produced++;
        end else begin
          int before_n;
          before_n = pending_q.size();
          add_row(2'($urandom));
          produced += pending_q.size() - before_n;
        end
      end
      if (ph == 1) begin
        hold = 1'b1;
        while (in_valid_i || expected_q.size() > 0) @(posedge clk_i);
        hold = 1'b0;
      end
      drain();
    end
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
